### rtl/bounded_array_list_macros.svh
// Assertion helpers shared by the list controller and datapath.
// Every check is disabled while reset is asserted.
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

// Condition must hold at every clock edge.
`define BAL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BAL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_PUSH   = 3'd2,
        OP_POP    = 3'd3,
        OP_INSERT = 3'd4,
        OP_REMOVE = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_FULL = 2'd2
    } st_t;

    // RAM read address source
    typedef enum logic [1:0] {
        RD_POS    = 2'd0,
        RD_LAST   = 2'd1,
        RD_PTR_DN = 2'd2,
        RD_PTR_UP = 2'd3
    } rd_sel_t;

    // RAM write address / data source
    typedef enum logic [1:0] {
        WR_POS_DIN   = 2'd0,
        WR_LEN_DIN   = 2'd1,
        WR_PTR_RDATA = 2'd2
    } wr_sel_t;

    typedef struct packed {
        logic    capture;
        logic    result_init;
        logic    dout_load;
        logic    ram_rd;
        rd_sel_t rd_sel;
        logic    ram_wr;
        wr_sel_t wr_sel;
        logic    ptr_init_ins;
        logic    ptr_init_rem;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    len_inc;
        logic    len_dec;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            chk_ok;
        logic            at_pos;
        logic            rem_last;
    } sts_t;

endpackage

### rtl/bal_ram.sv
// ----------------------------------------------------------------------------
// bal_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bal_dp.sv
// ----------------------------------------------------------------------------
// bal_dp
// List datapath: request registers, length, shift pointer, entry RAM, result.
// ----------------------------------------------------------------------------
`include "bounded_array_list_macros.svh"

module bal_dp #(
    parameter int CAPACITY = bal_pkg::CAPACITY_DEF,
    localparam int POS_W   = $clog2(CAPACITY + 1),
    localparam int ADDR_W  = $clog2(CAPACITY)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bal_pkg::cmd_t                cmd,
    output bal_pkg::sts_t                sts,
    input  logic [bal_pkg::OP_W-1:0]     operation,
    input  logic [POS_W-1:0]             position,
    input  logic signed [bal_pkg::DATA_W-1:0] data_in,
    output logic signed [bal_pkg::DATA_W-1:0] data_out,
    output logic [bal_pkg::ST_W-1:0]     status,
    output logic [POS_W-1:0]             count
);

    localparam logic [POS_W-1:0] CAP_LEN = POS_W'(CAPACITY);

    logic [bal_pkg::OP_W-1:0]   op_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [bal_pkg::DATA_W-1:0] din_reg;
    logic [POS_W-1:0]           len_reg, len_next;
    logic [POS_W-1:0]           ptr_reg, ptr_next;
    logic [bal_pkg::DATA_W-1:0] dout_reg;
    bal_pkg::st_t               status_reg;
    bal_pkg::st_t               chk_status;

    logic                       index_ok, ins_ok, empty, full;
    logic [POS_W-1:0]           len_m1, ptr_m1, ptr_p1;
    logic [POS_W:0]             ptr_p1_wide;
    logic [ADDR_W-1:0]          rd_addr, wr_addr;
    logic [bal_pkg::DATA_W-1:0] wr_data, rd_data;

    // request capture (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            din_reg <= data_in;
        end
        if (cmd.result_init)
        begin
            dout_reg <= '0;
        end
        else if (cmd.dout_load)
        begin
            dout_reg <= rd_data;
        end
        if (cmd.result_init)
        begin
            status_reg <= chk_status;
        end
        ptr_reg <= ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    assign index_ok = (pos_reg < len_reg);
    assign ins_ok   = (pos_reg <= len_reg);
    assign empty    = (len_reg == '0);
    assign full     = (len_reg == CAP_LEN);

    // range test first, then capacity
    always_comb
    begin
        case (bal_pkg::op_t'(op_reg))
            bal_pkg::OP_GET,
            bal_pkg::OP_SET,
            bal_pkg::OP_REMOVE: chk_status = index_ok ? bal_pkg::ST_OK : bal_pkg::ST_ERR;
            bal_pkg::OP_PUSH:   chk_status = full ? bal_pkg::ST_FULL : bal_pkg::ST_OK;
            bal_pkg::OP_POP:    chk_status = empty ? bal_pkg::ST_ERR : bal_pkg::ST_OK;
            bal_pkg::OP_INSERT:
            begin
                if (!ins_ok)
                begin
                    chk_status = bal_pkg::ST_ERR;
                end
                else if (full)
                begin
                    chk_status = bal_pkg::ST_FULL;
                end
                else
                begin
                    chk_status = bal_pkg::ST_OK;
                end
            end
            default:            chk_status = bal_pkg::ST_ERR;
        endcase
    end

    assign len_m1      = len_reg - 1'b1;
    assign ptr_m1      = ptr_reg - 1'b1;
    assign ptr_p1      = ptr_reg + 1'b1;
    assign ptr_p1_wide = {1'b0, ptr_reg} + 1'b1;

    always_comb
    begin
        len_next = len_reg;
        if (cmd.len_inc)
        begin
            len_next = len_reg + 1'b1;
        end
        else if (cmd.len_dec)
        begin
            len_next = len_m1;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_init_ins)
        begin
            ptr_next = len_reg;
        end
        else if (cmd.ptr_init_rem)
        begin
            ptr_next = pos_reg;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_m1;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_p1;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            bal_pkg::RD_POS:    rd_addr = pos_reg[ADDR_W-1:0];
            bal_pkg::RD_LAST:   rd_addr = len_m1[ADDR_W-1:0];
            bal_pkg::RD_PTR_DN: rd_addr = ptr_m1[ADDR_W-1:0];
            bal_pkg::RD_PTR_UP: rd_addr = ptr_p1[ADDR_W-1:0];
            default:            rd_addr = pos_reg[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            bal_pkg::WR_POS_DIN:
            begin
                wr_addr = pos_reg[ADDR_W-1:0];
                wr_data = din_reg;
            end
            bal_pkg::WR_LEN_DIN:
            begin
                wr_addr = len_reg[ADDR_W-1:0];
                wr_data = din_reg;
            end
            bal_pkg::WR_PTR_RDATA:
            begin
                wr_addr = ptr_reg[ADDR_W-1:0];
                wr_data = rd_data;
            end
            default:
            begin
                wr_addr = pos_reg[ADDR_W-1:0];
                wr_data = din_reg;
            end
        endcase
    end

    bal_ram #(
        .WIDTH (bal_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sts.op       = op_reg;
    assign sts.chk_ok   = (chk_status == bal_pkg::ST_OK);
    assign sts.at_pos   = (ptr_reg == pos_reg);
    assign sts.rem_last = (ptr_p1_wide >= {1'b0, len_reg});

    assign data_out = dout_reg;
    assign status   = status_reg;
    assign count    = len_reg;

    `BAL_ASSERT_ALWAYS(a_len_bound, clk, rst_n, len_reg <= CAP_LEN, "length above capacity")
    `BAL_ASSERT_IMPLY(a_inc_not_full, clk, rst_n, cmd.len_inc, !full, "grow on full list")
    `BAL_ASSERT_IMPLY(a_dec_not_empty, clk, rst_n, cmd.len_dec, !empty, "shrink on empty list")

endmodule

### rtl/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl
// Request sequencer: decode, entry shifts for insert/remove, result handshake.
// ----------------------------------------------------------------------------
`include "bounded_array_list_macros.svh"

module bal_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  bal_pkg::sts_t sts,
    output bal_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_READ     = 9'b000000100,
        S_INS_RD   = 9'b000001000,
        S_INS_WR   = 9'b000010000,
        S_REM_LOAD = 9'b000100000,
        S_REM_RD   = 9'b001000000,
        S_REM_WR   = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.result_init = 1'b1;
                state_next      = S_RESP;
                if (sts.chk_ok)
                begin
                    case (bal_pkg::op_t'(sts.op))
                        bal_pkg::OP_GET:
                        begin
                            cmd.ram_rd = 1'b1;
                            cmd.rd_sel = bal_pkg::RD_POS;
                            state_next = S_READ;
                        end
                        bal_pkg::OP_SET:
                        begin
                            cmd.ram_wr = 1'b1;
                            cmd.wr_sel = bal_pkg::WR_POS_DIN;
                        end
                        bal_pkg::OP_PUSH:
                        begin
                            cmd.ram_wr  = 1'b1;
                            cmd.wr_sel  = bal_pkg::WR_LEN_DIN;
                            cmd.len_inc = 1'b1;
                        end
                        bal_pkg::OP_POP:
                        begin
                            cmd.ram_rd  = 1'b1;
                            cmd.rd_sel  = bal_pkg::RD_LAST;
                            cmd.len_dec = 1'b1;
                            state_next  = S_READ;
                        end
                        bal_pkg::OP_INSERT:
                        begin
                            cmd.ptr_init_ins = 1'b1;
                            state_next       = S_INS_RD;
                        end
                        bal_pkg::OP_REMOVE:
                        begin
                            cmd.ram_rd       = 1'b1;
                            cmd.rd_sel       = bal_pkg::RD_POS;
                            cmd.ptr_init_rem = 1'b1;
                            state_next       = S_REM_LOAD;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.dout_load = 1'b1;
                state_next    = S_RESP;
            end
            S_INS_RD:
            begin
                if (sts.at_pos)
                begin
                    cmd.ram_wr  = 1'b1;
                    cmd.wr_sel  = bal_pkg::WR_POS_DIN;
                    cmd.len_inc = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    cmd.rd_sel = bal_pkg::RD_PTR_DN;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.ram_wr  = 1'b1;
                cmd.wr_sel  = bal_pkg::WR_PTR_RDATA;
                cmd.ptr_dec = 1'b1;
                state_next  = S_INS_RD;
            end
            S_REM_LOAD:
            begin
                cmd.dout_load = 1'b1;
                state_next    = S_REM_RD;
            end
            S_REM_RD:
            begin
                if (sts.rem_last)
                begin
                    cmd.len_dec = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    cmd.rd_sel = bal_pkg::RD_PTR_UP;
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                cmd.ram_wr  = 1'b1;
                cmd.wr_sel  = bal_pkg::WR_PTR_RDATA;
                cmd.ptr_inc = 1'b1;
                state_next  = S_REM_RD;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BAL_ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "request overlaps result")
    `BAL_ASSERT_NEXT(a_decode_first, clk, rst_n, in_valid && in_ready, !out_valid && !in_ready,
        "result shown before decode")
    `BAL_ASSERT_ALWAYS(a_one_port_op, clk, rst_n, !(cmd.ram_rd && cmd.ram_wr), "read and write together")

endmodule

### rtl/bounded_array_list.sv
// Flow: a request is captured in idle and checked in decode; get and pop pass a read state,
// insert and remove walk their shift loop, and every request ends in the result state.
// Throughput: one request at a time; each shifted entry costs one RAM read and one write.
// Next request is taken the cycle after the result is taken.
// Reset (rst_n, async, active low) empties the list; entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
// bounded_array_list
// Fixed-capacity ordered list of signed 32-bit values with get/set/push/pop/
// insert/remove requests, built as a sequencer plus a RAM-based datapath.
// ----------------------------------------------------------------------------
module bounded_array_list #(
    parameter int CAPACITY = bal_pkg::CAPACITY_DEF,
    localparam int POS_W   = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bal_pkg::OP_W-1:0]          operation,
    input  logic [POS_W-1:0]                  position,
    input  logic signed [bal_pkg::DATA_W-1:0] data_in,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [bal_pkg::DATA_W-1:0] data_out,
    output logic [bal_pkg::ST_W-1:0]          status,
    output logic [POS_W-1:0]                  count
);

    bal_pkg::cmd_t cmd;
    bal_pkg::sts_t sts;

    // Sequencer: accepts a request in idle, checks it, walks the shift loop
    // for insert (top down) and remove (bottom up), then holds the result
    // until the downstream side takes it.
    bal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: request registers, length and shift pointer, entry RAM and
    // result registers. Result fields stay stable while out_valid is high.
    bal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .operation (operation),
        .position  (position),
        .data_in   (data_in),
        .data_out  (data_out),
        .status    (status),
        .count     (count)
    );

endmodule

### test/list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the request and result channels of the bounded list, keeps its own
// copy of the list contents and length, and compares every result with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module list_checker #(
    parameter int CAPACITY = bal_pkg::CAPACITY_DEF,
    localparam int POS_W   = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [bal_pkg::OP_W-1:0]          operation,
    input  logic [POS_W-1:0]                  position,
    input  logic signed [bal_pkg::DATA_W-1:0] data_in,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [bal_pkg::DATA_W-1:0] data_out,
    input  logic [bal_pkg::ST_W-1:0]          status,
    input  logic [POS_W-1:0]                  count,
    output int                                fail_count,
    output int                                pending,
    output int                                results_checked,
    output int                                full_refusals,
    output int                                error_statuses
);
    import bal_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        st_t                      st;
        logic [POS_W-1:0]         len;
    } list_result_t;

    logic signed [DATA_W-1:0] entry_mem [CAPACITY];
    logic [POS_W-1:0]         list_len;
    list_result_t             result_q [$];

    // Applies one request to the shadow list and returns the result it gives.
    function automatic list_result_t apply_request(
        input logic [OP_W-1:0]          op,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] din
    );
        list_result_t r;
        int p;
        int n;
        r.value = '0;
        r.st    = ST_OK;
        p       = int'(pos);
        n       = int'(list_len);
        case (op)
            OP_GET:
                if (p < n) r.value = entry_mem[p];
                else       r.st = ST_ERR;
            OP_SET:
                if (p < n) entry_mem[p] = din;
                else       r.st = ST_ERR;
            OP_PUSH:
                if (n >= CAPACITY) begin
                    r.st = ST_FULL;
                end else begin
                    entry_mem[n] = din;
                    list_len     = POS_W'(n + 1);
                end
            OP_POP:
                if (n == 0) begin
                    r.st = ST_ERR;
                end else begin
                    r.value  = entry_mem[n - 1];
                    list_len = POS_W'(n - 1);
                end
            OP_INSERT:
                // range test takes precedence over the full test
                if (p > n) begin
                    r.st = ST_ERR;
                end else if (n >= CAPACITY) begin
                    r.st = ST_FULL;
                end else begin
                    for (int k = n; k > p; k--) entry_mem[k] = entry_mem[k - 1];
                    entry_mem[p] = din;
                    list_len     = POS_W'(n + 1);
                end
            OP_REMOVE:
                if (p < n) begin
                    r.value = entry_mem[p];
                    for (int k = p; k + 1 < n; k++) entry_mem[k] = entry_mem[k + 1];
                    list_len = POS_W'(n - 1);
                end else begin
                    r.st = ST_ERR;
                end
            default:
                r.st = ST_ERR;
        endcase
        r.len = list_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("list_checker: %0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        list_result_t oldest;
        list_result_t fresh;
        if (!rst_n) begin
            list_len = '0;
            result_q.delete();
            pending         <= 0;
            fail_count      = 0;
            results_checked = 0;
            full_refusals   = 0;
            error_statuses  = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result with no request outstanding, data_out",
                                    0, data_out);
                end else begin
                    oldest = result_q.pop_front();
                    if (data_out !== oldest.value)
                        report_mismatch("data_out", oldest.value, data_out);
                    if (status !== oldest.st)
                        report_mismatch("status", oldest.st, status);
                    if (count !== oldest.len)
                        report_mismatch("count", oldest.len, count);
                    results_checked++;
                end
            end
            if (in_valid && in_ready) begin
                fresh = apply_request(operation, position, data_in);
                if (fresh.st == ST_FULL) full_refusals++;
                if (fresh.st == ST_ERR)  error_statuses++;
                result_q.push_back(fresh);
            end
            // nonblocking so the stimulus side sees a stable value at each edge
            pending <= result_q.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bounded list. A short directed sequence hits
// the empty, out-of-range and unknown-operation cases, then phased
// random traffic grows, fills and drains the list under random idling on
// both channels. Checking is done by list_checker alongside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import bal_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int POS_W        = $clog2(CAPACITY + 1);
    localparam int PHASE_COUNT  = 20;
    localparam int PHASE_LEN    = 100;     // 20 x 100 random requests
    localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 200;     // idle time at the end, in cycles
    // Slowest legal run: ~2025 requests, each a full-length insert plus a
    // longest receiver stall and a longest sender gap; the limit allows
    // about four and a half times that run.
    localparam int LIMIT_NS     = 20_000_000;

    // operation codes the block does not know; both must give an error
    localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_MIXED,
        PH_FILL
    } phase_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          operation = '0;
    logic [POS_W-1:0]         position  = '0;
    logic signed [DATA_W-1:0] data_in   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] data_out;
    logic [ST_W-1:0]          status;
    logic [POS_W-1:0]         count;

    int fail_count;
    int pending;
    int results_checked;
    int full_refusals;
    int error_statuses;

    int   requests_sent = 0;
    int   cur_len       = 0;      // list length as last reported by the block
    logic hold_off_req  = 1'b0;   // asks the receiver for one long hold-off
    logic no_idle       = 1'b0;   // stretch with both sides running flat out

    bounded_array_list #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .position  (position),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .status    (status),
        .count     (count)
    );

    list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .position        (position),
        .data_in         (data_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_out        (data_out),
        .status          (status),
        .count           (count),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .full_refusals   (full_refusals),
        .error_statuses  (error_statuses)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #LIMIT_NS;
        $display("tb_top: errors");
        $finish;
    end

    // Track the reported length so random positions land mostly in range.
    // Being a request behind now and then only adds a few extra errors.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            cur_len <= int'(count);
    end

    // Idle length: nine times in ten from the short range, else a long stretch.
    function automatic int idle_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req <= 1'b0;
                out_ready    <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // Offer one request, with an optional gap first, and hold it until taken.
    // Valid is only lowered when a gap is wanted, so back-to-back requests
    // keep it high across the edge.
    task automatic send_request(
        input logic [OP_W-1:0]          op,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] din
    );
        int gap;
        gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        position  <= pos;
        data_in   <= din;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    // Sender pause: drop valid and wait until every result is back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input phase_t ph);
        int grow_pct;
        int shrink_pct;
        int r;
        case (ph)
            PH_GROW:   begin grow_pct = 70; shrink_pct = 10; end
            PH_SHRINK: begin grow_pct = 10; shrink_pct = 70; end
            PH_FILL:   begin grow_pct = 90; shrink_pct = 0;  end
            default:   begin grow_pct = 35; shrink_pct = 35; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 2)
            return $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
        r = $urandom_range(0, 99);
        if (r < grow_pct)
            return $urandom_range(0, 1) ? OP_INSERT : OP_PUSH;
        if (r < grow_pct + shrink_pct)
            return $urandom_range(0, 1) ? OP_REMOVE : OP_POP;
        return $urandom_range(0, 1) ? OP_SET : OP_GET;
    endfunction

    // Mostly valid positions, with the ends of the range favoured, some just
    // past the end and a few anywhere in the field.
    function automatic logic [POS_W-1:0] pick_pos(input logic [OP_W-1:0] op);
        int top_ok;
        int r;
        int p;
        top_ok = (op == OP_INSERT) ? cur_len : cur_len - 1;
        r = $urandom_range(0, 99);
        if (r >= 95)
            p = $urandom_range(0, (1 << POS_W) - 1);
        else if (top_ok < 0)
            p = $urandom_range(0, 3);
        else if (r < 10)
            p = 0;
        else if (r < 20)
            p = top_ok;
        else if (r < 85)
            p = $urandom_range(0, top_ok);
        else
            p = top_ok + $urandom_range(1, 2);
        if (p > (1 << POS_W) - 1)
            p = (1 << POS_W) - 1;
        return POS_W'(p);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 32'sh7fff_ffff;
        if (r < 10) return 32'sh8000_0000;
        if (r < 13) return '0;
        if (r < 16) return -32'sd1;
        return $urandom;
    endfunction

    initial
    begin
        phase_t           ph;
        logic [OP_W-1:0]  op;

        // reset held from the start, released on a rising edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // empty list: every reading or removing request must fail
        send_request(OP_POP,    7'd0,   32'sd11);
        send_request(OP_GET,    7'd0,   32'sd0);
        send_request(OP_REMOVE, 7'd0,   32'sd0);
        send_request(OP_SET,    7'd0,   32'sd5);
        send_request(OP_INSERT, 7'd1,   32'sd6);   // one past the end of an empty list
        send_request(OP_BAD_LO, 7'd0,   32'sd1);
        send_request(OP_BAD_HI, 7'd127, -32'sd1);
        // build a few entries, extremes of the value range among them
        send_request(OP_INSERT, 7'd0,   32'sh7fff_ffff);
        send_request(OP_PUSH,   7'd0,   32'sh8000_0000);
        send_request(OP_PUSH,   7'd127, 32'sd0);
        send_request(OP_PUSH,   7'd0,   -32'sd1);
        send_request(OP_GET,    7'd0,   32'sd0);
        send_request(OP_GET,    7'd3,   32'sd0);   // last entry
        send_request(OP_GET,    7'd4,   32'sd0);   // position equal to length
        send_request(OP_GET,    7'd127, 32'sd0);
        send_request(OP_SET,    7'd1,   32'sh5555_5555);
        send_request(OP_SET,    7'd127, 32'sh2aaa_aaaa);
        send_request(OP_INSERT, 7'd2,   32'sd1234);  // middle
        send_request(OP_INSERT, 7'd5,   32'sd4321);  // at the end, acts as append
        send_request(OP_INSERT, 7'd7,   32'sd99);    // past the end
        send_request(OP_REMOVE, 7'd0,   32'sd0);     // first
        send_request(OP_REMOVE, 7'd4,   32'sd0);     // last
        send_request(OP_REMOVE, 7'd1,   32'sd0);     // middle
        send_request(OP_POP,    7'd0,   32'sd0);
        send_request(OP_GET,    7'd1,   32'sd0);
        wait_drained();

        // ---- random, in phases that steer the list length ----
        // Fill phases push the list to capacity and keep knocking on it;
        // one phase gets the long receiver hold-off, another runs with no
        // idling at all.
        for (int ph_idx = 0; ph_idx < PHASE_COUNT; ph_idx++)
        begin
            if (ph_idx == 2 || ph_idx == 9 || ph_idx == 15)
                ph = PH_FILL;
            else
                ph = phase_t'($urandom_range(0, 2));
            no_idle <= (ph_idx == 7);
            if (ph_idx == 5)
                hold_off_req <= 1'b1;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                op = pick_op(ph);
                send_request(op, pick_pos(op), pick_data());
            end
            if (ph_idx % 4 == 3)
                wait_drained();
        end

        // ---- wind down ----
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d requests sent, %0d results checked", requests_sent,
                 results_checked);
        $display("tb_top: %0d full-list refusals, %0d error statuses, %0d mismatches",
                 full_refusals, error_statuses, fail_count);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
